// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the rational arithmetic unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk, switched off while rst_n is low.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion of a relation that must hold in the cycle after a trigger.
`define ASSERT_NEXT(label, trig, prop, msg) \
    `ASSERT_PROP(label, (trig) |=> (prop), msg)

`endif

// File: rtl/core/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Constants, operation codes and control structures of the rational unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
    localparam int WIDE_WIDTH    = 65;
    localparam int MAG_WIDTH     = 64;
    localparam int NUM_WIDTH     = 64;
    localparam int DEN_WIDTH     = 63;
    localparam int FIELD_WIDTH   = 32;
    localparam int CMD_WIDTH     = 4;
    localparam int ERR_WIDTH     = 2;
    localparam int SHIFT_WIDTH   = 7;
    localparam int CNT_WIDTH     = 6;

    // Operation codes.
    localparam logic [CMD_WIDTH-1:0] CMD_MUL   = 4'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_DIV   = 4'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_SUB   = 4'd2;
    localparam logic [CMD_WIDTH-1:0] CMD_LESS  = 4'd3;
    localparam logic [CMD_WIDTH-1:0] CMD_EQUAL = 4'd4;
    localparam logic [CMD_WIDTH-1:0] CMD_GEQ   = 4'd5;
    localparam logic [CMD_WIDTH-1:0] CMD_NEG   = 4'd6;
    localparam logic [CMD_WIDTH-1:0] CMD_NORM  = 4'd7;
    localparam logic [CMD_WIDTH-1:0] CMD_ABS   = 4'd8;

    // Error codes.
    localparam logic [ERR_WIDTH-1:0] ERR_OK       = 2'd0;
    localparam logic [ERR_WIDTH-1:0] ERR_ZERO_DEN = 2'd1;
    localparam logic [ERR_WIDTH-1:0] ERR_OVERFLOW = 2'd2;

    // Multiplier steps.
    localparam logic [1:0] MUL_NUM   = 2'd0;
    localparam logic [1:0] MUL_CROSS = 2'd1;
    localparam logic [1:0] MUL_DEN   = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_step;
        logic       diff_en;
        logic       mag_en;
        logic       gcd_init;
        logic       gcd_step;
        logic       gcd_fin;
        logic       div_load;
        logic       div_sel_den;
        logic       div_step;
        logic       out_load;
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip;
        logic short_path;
        logic gcd_done;
    } stat_t;

endpackage

// File: rtl/core/rau_if.sv
// ----------------------------------------------------------------------------
// rau_if
// Valid/ready channels for operand items and result items.
// ----------------------------------------------------------------------------
interface rau_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  cmd;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;

    modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic        valid;
    logic        ready;
    logic signed [63:0] res_num;
    logic [62:0] res_den;
    logic        cmp_true;
    logic [1:0]  err_code;

    modport source (output valid, res_num, res_den, cmp_true, err_code, input ready);
    modport sink   (input valid, res_num, res_den, cmp_true, err_code, output ready);
endinterface

// File: rtl/core/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact fraction arithmetic with gcd reduction.
// ----------------------------------------------------------------------------
// Usage: operand items enter on the "in" channel (cmd and two fractions), one
// result item leaves on the "out" channel per operand item, in order.
// An item moves when valid and ready are both high at a rising clock edge.
// One item is worked on at a time. Errors and unused codes go from operand
// capture straight to the result register; compares and zero results first
// pass the multiplier, difference and magnitude steps. Other fraction
// results then run a binary gcd of one halving or subtraction per cycle,
// form the gcd, make two exact divisions of 64-bit magnitudes on one
// restoring divider and load the result. The gcd loop and the shared
// divider take most of the working time.
// The result sits in an output register, so while the receiver stalls the
// next operand item is already accepted and worked on; it waits in its last
// step until the output register is free. Reset (rst_n low, asynchronous)
// returns the sequencer to idle and drops out.valid; no clearing pass is
// needed and the unit is ready for an item as soon as reset ends.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    rau_in_if.sink   in,
    rau_out_if.source out
);

    ctrl_t ctrl;
    stat_t stat;

    // Sequencer.
    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in.valid),
        .in_ready  (in.ready),
        .out_valid (out.valid),
        .out_ready (out.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // Arithmetic datapath.
    rau_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .cmd      (in.cmd),
        .a_num    (in.a_num),
        .a_den    (in.a_den),
        .b_num    (in.b_num),
        .b_den    (in.b_den),
        .stat     (stat),
        .res_num  (out.res_num),
        .res_den  (out.res_den),
        .cmp_true (out.cmp_true),
        .err_code (out.err_code)
    );

endmodule

// File: rtl/core/rau_datapath.sv
// ----------------------------------------------------------------------------
// rau_datapath
// Operand registers, shared multiplier, binary gcd unit, restoring divider
// and result registers of the rational unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rau_datapath
    import rau_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  ctrl_t                        ctrl,
    input  logic [CMD_WIDTH-1:0]         cmd,
    input  logic signed [FIELD_WIDTH-1:0] a_num,
    input  logic signed [FIELD_WIDTH-1:0] a_den,
    input  logic signed [FIELD_WIDTH-1:0] b_num,
    input  logic signed [FIELD_WIDTH-1:0] b_den,
    output stat_t                        stat,
    output logic signed [NUM_WIDTH-1:0]  res_num,
    output logic [DEN_WIDTH-1:0]         res_den,
    output logic                         cmp_true,
    output logic [ERR_WIDTH-1:0]         err_code
);

    localparam logic signed [OPERAND_WIDTH-1:0] OP_ONE  = OPERAND_WIDTH'(1);
    localparam logic signed [OPERAND_WIDTH-1:0] OP_ZERO = '0;

    logic [CMD_WIDTH-1:0]             cmd_reg;
    logic signed [OPERAND_WIDTH-1:0]  an_reg, ad_reg, bn_reg, bd_reg;
    logic [ERR_WIDTH-1:0]             err_reg;
    logic                             skip_reg;
    logic signed [PROD_WIDTH-1:0]     pn_reg, py_reg, pd_reg;
    logic signed [WIDE_WIDTH-1:0]     numv_reg;
    logic                             cmp_reg;
    logic [MAG_WIDTH-1:0]             nm_reg, dm_reg;
    logic                             n_neg_reg, d_neg_reg;
    logic [MAG_WIDTH-1:0]             u_reg, v_reg, g_reg;
    logic [SHIFT_WIDTH-1:0]           k_reg;
    logic [MAG_WIDTH-1:0]             rem_reg, quo_reg, qn_reg;
    logic signed [NUM_WIDTH-1:0]      res_num_reg;
    logic [DEN_WIDTH-1:0]             res_den_reg;
    logic                             cmp_true_reg;
    logic [ERR_WIDTH-1:0]             err_code_reg;

    logic signed [OPERAND_WIDTH-1:0]  an_w, ad_w, bn_w, bd_w;
    logic                             uses_b, in_err, is_cmp, is_unary;
    logic signed [OPERAND_WIDTH-1:0]  ma, mb;
    logic signed [PROD_WIDTH-1:0]     prod;
    logic signed [WIDE_WIDTH-1:0]     pn_x, py_x, pd_x;
    logic                             lt, eq;
    logic [WIDE_WIDTH-1:0]            num_abs, den_abs;
    logic [MAG_WIDTH:0]               trial;
    logic [MAG_WIDTH:0]               trial_diff;
    logic                             neg;

    // Operands are the low bits of each field.
    assign an_w = a_num[OPERAND_WIDTH-1:0];
    assign ad_w = a_den[OPERAND_WIDTH-1:0];
    assign bn_w = b_num[OPERAND_WIDTH-1:0];
    assign bd_w = b_den[OPERAND_WIDTH-1:0];

    assign uses_b = (cmd <= CMD_GEQ);
    assign in_err = (ad_w == OP_ZERO) || (uses_b && bd_w == OP_ZERO)
                    || (cmd == CMD_DIV && bn_w == OP_ZERO);

    assign is_cmp   = (cmd_reg inside {CMD_LESS, CMD_EQUAL, CMD_GEQ});
    assign is_unary = (cmd_reg inside {CMD_NEG, CMD_NORM, CMD_ABS});

    // Operand capture and input checks.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg  <= ERR_OK;
            skip_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            err_reg  <= (cmd <= CMD_ABS && in_err) ? ERR_ZERO_DEN : ERR_OK;
            skip_reg <= (cmd > CMD_ABS) || in_err;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= cmd;
            an_reg  <= an_w;
            ad_reg  <= ad_w;
            bn_reg  <= bn_w;
            bd_reg  <= bd_w;
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        ma = an_reg;
        mb = OP_ZERO;
        case (ctrl.mul_step)
            MUL_NUM:
            begin
                ma = an_reg;
                if (cmd_reg == CMD_MUL)
                    mb = bn_reg;
                else if (is_unary)
                    mb = OP_ONE;
                else
                    mb = bd_reg;
            end
            MUL_CROSS:
            begin
                ma = bn_reg;
                mb = (cmd_reg == CMD_SUB || is_cmp) ? ad_reg : OP_ZERO;
            end
            MUL_DEN:
            begin
                ma = ad_reg;
                if (cmd_reg == CMD_DIV)
                    mb = bn_reg;
                else if (is_unary)
                    mb = OP_ONE;
                else
                    mb = bd_reg;
            end
            default:
            begin
                ma = an_reg;
                mb = OP_ZERO;
            end
        endcase
    end

    assign prod = ma * mb;

    // Product registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            case (ctrl.mul_step)
                MUL_NUM:   pn_reg <= prod;
                MUL_CROSS: py_reg <= prod;
                MUL_DEN:   pd_reg <= prod;
                default:   pd_reg <= prod;
            endcase
        end
    end

    assign pn_x = WIDE_WIDTH'(pn_reg);
    assign py_x = WIDE_WIDTH'(py_reg);
    assign pd_x = WIDE_WIDTH'(pd_reg);

    // Cross-multiplied compare; a negative denominator product swaps sides.
    assign lt = pd_reg[PROD_WIDTH-1] ? (py_x < pn_x) : (pn_x < py_x);
    assign eq = (pn_x == py_x);

    always_ff @(posedge clk)
    begin
        if (ctrl.diff_en)
        begin
            numv_reg <= (cmd_reg == CMD_SUB) ? (pn_x - py_x) : pn_x;
            case (cmd_reg)
                CMD_LESS:  cmp_reg <= lt;
                CMD_EQUAL: cmp_reg <= eq;
                CMD_GEQ:   cmp_reg <= !lt;
                default:   cmp_reg <= 1'b0;
            endcase
        end
    end

    // Magnitudes and signs of numerator and denominator.
    assign num_abs = numv_reg[WIDE_WIDTH-1] ? WIDE_WIDTH'(-numv_reg) : numv_reg;
    assign den_abs = pd_x[WIDE_WIDTH-1] ? WIDE_WIDTH'(-pd_x) : pd_x;

    always_ff @(posedge clk)
    begin
        if (ctrl.mag_en)
        begin
            nm_reg <= num_abs[MAG_WIDTH-1:0];
            dm_reg <= den_abs[MAG_WIDTH-1:0];
            case (cmd_reg)
                CMD_NEG:
                begin
                    n_neg_reg <= !numv_reg[WIDE_WIDTH-1];
                    d_neg_reg <= pd_reg[PROD_WIDTH-1];
                end
                CMD_ABS:
                begin
                    n_neg_reg <= 1'b0;
                    d_neg_reg <= 1'b0;
                end
                default:
                begin
                    n_neg_reg <= numv_reg[WIDE_WIDTH-1];
                    d_neg_reg <= pd_reg[PROD_WIDTH-1];
                end
            endcase
        end
    end

    // Binary gcd: one halving or one subtraction per cycle.
    always_ff @(posedge clk)
    begin
        if (ctrl.gcd_init)
        begin
            u_reg <= nm_reg;
            v_reg <= dm_reg;
            k_reg <= '0;
        end
        else if (ctrl.gcd_step && u_reg != '0)
        begin
            if (!u_reg[0] && !v_reg[0])
            begin
                u_reg <= u_reg >> 1;
                v_reg <= v_reg >> 1;
                k_reg <= k_reg + SHIFT_WIDTH'(1);
            end
            else if (!u_reg[0])
                u_reg <= u_reg >> 1;
            else if (!v_reg[0])
                v_reg <= v_reg >> 1;
            else if (u_reg >= v_reg)
                u_reg <= u_reg - v_reg;
            else
                v_reg <= v_reg - u_reg;
        end
        if (ctrl.gcd_fin)
            g_reg <= v_reg << k_reg;
    end

    // Restoring divider, one quotient bit per cycle.
    assign trial      = {1'b0, rem_reg[MAG_WIDTH-2:0], quo_reg[MAG_WIDTH-1]};
    assign trial_diff = trial - {1'b0, g_reg};

    always_ff @(posedge clk)
    begin
        if (ctrl.div_load)
        begin
            rem_reg <= '0;
            quo_reg <= ctrl.div_sel_den ? dm_reg : nm_reg;
            if (ctrl.div_sel_den)
                qn_reg <= quo_reg;
        end
        else if (ctrl.div_step)
        begin
            if (!trial_diff[MAG_WIDTH])
            begin
                rem_reg <= trial_diff[MAG_WIDTH-1:0];
                quo_reg <= {quo_reg[MAG_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[MAG_WIDTH-1:0];
                quo_reg <= {quo_reg[MAG_WIDTH-2:0], 1'b0};
            end
        end
    end

    // Result register.
    assign neg = n_neg_reg ^ d_neg_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            res_num_reg  <= '0;
            res_den_reg  <= DEN_WIDTH'(1);
            cmp_true_reg <= 1'b0;
            err_code_reg <= ERR_OK;
            if (skip_reg)
                err_code_reg <= err_reg;
            else if (is_cmp)
                cmp_true_reg <= cmp_reg;
            else if (nm_reg == '0)
                res_num_reg <= '0;
            else if (!neg && qn_reg[MAG_WIDTH-1])
                err_code_reg <= ERR_OVERFLOW;
            else
            begin
                res_num_reg <= neg ? -$signed(qn_reg) : $signed(qn_reg);
                res_den_reg <= quo_reg[DEN_WIDTH-1:0];
            end
        end
    end

    assign stat.skip       = skip_reg;
    assign stat.short_path = is_cmp || (nm_reg == '0);
    assign stat.gcd_done   = (u_reg == '0);

    assign res_num  = res_num_reg;
    assign res_den  = res_den_reg;
    assign cmp_true = cmp_true_reg;
    assign err_code = err_code_reg;

    `ASSERT_PROP(a_gcd_v_nonzero, ctrl.gcd_step |-> (v_reg != '0), "gcd operand v reached zero")
    `ASSERT_NEXT(a_den_nonzero, ctrl.out_load, (res_den_reg != '0), "result denominator is zero")
    `ASSERT_PROP(a_div_nonzero, ctrl.div_step |-> (g_reg != '0), "divider runs with zero divisor")

endmodule

// File: rtl/core/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer of the rational unit: multiply, reduce, divide, deliver.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rau_ctrl
    import rau_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output ctrl_t ctrl
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_DIFF, S_MAGS, S_CHECK,
        S_GCD, S_DLN, S_DIVN, S_DLD, S_DIVD, S_FINAL
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // Next state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctrl           = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                if (stat.skip)
                    state_next = S_FINAL;
                else
                begin
                    ctrl.mul_en   = 1'b1;
                    ctrl.mul_step = MUL_NUM;
                    state_next    = S_MUL1;
                end
            end
            S_MUL1:
            begin
                ctrl.mul_en   = 1'b1;
                ctrl.mul_step = MUL_CROSS;
                state_next    = S_MUL2;
            end
            S_MUL2:
            begin
                ctrl.mul_en   = 1'b1;
                ctrl.mul_step = MUL_DEN;
                state_next    = S_DIFF;
            end
            S_DIFF:
            begin
                ctrl.diff_en = 1'b1;
                state_next   = S_MAGS;
            end
            S_MAGS:
            begin
                ctrl.mag_en = 1'b1;
                state_next  = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.short_path)
                    state_next = S_FINAL;
                else
                begin
                    ctrl.gcd_init = 1'b1;
                    state_next    = S_GCD;
                end
            end
            S_GCD:
            begin
                if (stat.gcd_done)
                begin
                    ctrl.gcd_fin = 1'b1;
                    state_next   = S_DLN;
                end
                else
                    ctrl.gcd_step = 1'b1;
            end
            S_DLN:
            begin
                ctrl.div_load = 1'b1;
                cnt_next      = '0;
                state_next    = S_DIVN;
            end
            S_DIVN:
            begin
                ctrl.div_step = 1'b1;
                cnt_next      = cnt_reg + CNT_WIDTH'(1);
                if (cnt_reg == '1)
                    state_next = S_DLD;
            end
            S_DLD:
            begin
                ctrl.div_load    = 1'b1;
                ctrl.div_sel_den = 1'b1;
                cnt_next         = '0;
                state_next       = S_DIVD;
            end
            S_DIVD:
            begin
                ctrl.div_step = 1'b1;
                cnt_next      = cnt_reg + CNT_WIDTH'(1);
                if (cnt_reg == '1)
                    state_next = S_FINAL;
            end
            S_FINAL:
            begin
                if (slot_free)
                begin
                    ctrl.out_load  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    `ASSERT_NEXT(a_div_count_start, (state_reg == S_DLN || state_reg == S_DLD), (cnt_reg == '0), "divider count not cleared")
    `ASSERT_PROP(a_valid_from_final, $rose(out_valid_reg) |-> ($past(state_reg) == S_FINAL), "result raised outside delivery")
    `ASSERT_PROP(a_load_when_free, ctrl.out_load |-> slot_free, "result overwritten while stalled")

endmodule
